// ===== src/vdf_pkg.sv =====
// Package for the volume divergence filter: widths, register indexes,
// input action codes and the structs passed between the control and datapath.
// Depends on nothing; every other file of the block but vdf_bank uses it.
package vdf_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int FRAC_BITS      = 12;
  localparam int SCALE_W        = 18;
  localparam int DIM_W          = 13;
  localparam int Z_W            = 12;
  localparam int DEPTH_LIMIT    = 4096;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 18;
  localparam int PROD_W         = 36;
  localparam int SUM_W          = 38;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_VOL_WIDTH  = 3'd0;
  localparam cfg_idx_t REG_VOL_HEIGHT = 3'd1;
  localparam cfg_idx_t REG_VOL_DEPTH  = 3'd2;
  localparam cfg_idx_t REG_N_COMP     = 3'd3;
  localparam cfg_idx_t REG_SCALE_X    = 3'd4;
  localparam cfg_idx_t REG_SCALE_Y    = 3'd5;
  localparam cfg_idx_t REG_SCALE_Z    = 3'd6;

  typedef enum logic {
    ACT_VOXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  // Axis scales, unsigned Q6.12.
  typedef struct packed {
    logic [SCALE_W-1:0] sx;
    logic [SCALE_W-1:0] sy;
    logic [SCALE_W-1:0] sz;
  } scale_t;

  // Per-result control carried alongside the plane store reads.
  typedef struct packed {
    logic                          last;
    logic                          use_y;
    logic                          use_z;
    logic                          nz_sel;
    logic signed [SAMPLE_BITS-1:0] nz;
  } emit_t;

endpackage

// ===== src/vdf_bank.sv =====
// One component bank of the plane store: one write port and two read ports,
// read data registered. Depends on nothing but its parameters.
module vdf_bank #(
  parameter int AW = 17,
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rd_a_q;
  logic [DW-1:0] rd_b_q;

  // Reads return the old contents when the same entry is written.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_a_q <= mem_q[raddr_a_i];
      rd_b_q <= mem_q[raddr_b_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

// ===== src/vdf_ctrl.sv =====
// Control of the divergence filter: configuration registers, input and
// output voxel positions, and plane store addresses. Depends on vdf_pkg.
module vdf_ctrl #(
  parameter int MAX_WIDTH  = vdf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = vdf_pkg::DEF_MAX_HEIGHT,
  parameter int XB         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int YB         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  parameter int AW         = 1 + XB + YB
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  vdf_pkg::cfg_idx_t                 cfg_index_i,
  input  logic [vdf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              action_i,
  input  logic signed [vdf_pkg::SAMPLE_BITS-1:0] comp_z_i,
  output logic                              write_o,
  output logic [AW-1:0]                     waddr_o,
  output logic [AW-1:0]                     x_prev_o,
  output logic [AW-1:0]                     x_next_o,
  output logic [AW-1:0]                     y_prev_o,
  output logic [AW-1:0]                     y_next_o,
  output logic [AW-1:0]                     z_prev_o,
  output logic [AW-1:0]                     ctr_o,
  output logic                              emit_o,
  output vdf_pkg::emit_t                    info_o,
  output vdf_pkg::scale_t                   scale_o
);

  localparam int DW = vdf_pkg::DIM_W;
  localparam int ZW = vdf_pkg::Z_W;

  logic [8:0]                    vol_width_q, vol_width_d;
  logic [8:0]                    vol_height_q, vol_height_d;
  logic [12:0]                   vol_depth_q, vol_depth_d;
  logic [1:0]                    n_comp_q, n_comp_d;
  vdf_pkg::scale_t               scale_q, scale_d;
  logic [XB-1:0]                 in_x_q, in_x_d, out_x_q, out_x_d;
  logic [YB-1:0]                 in_y_q, in_y_d, out_y_q, out_y_d;
  logic [ZW-1:0]                 in_z_q, in_z_d, out_z_q, out_z_d;
  logic                          done_q, done_d;

  logic [DW-1:0] w_eff, h_eff, d_eff;
  logic [1:0]    nc_eff;
  logic          accept, cfg_hit;
  logic          in_x_end, in_y_end, in_z_end, in_last;
  logic          out_x_end, out_y_end, out_z_end, out_last;
  logic [XB-1:0] xm, xp;
  logic [YB-1:0] ym, yp;

  // Register values clamped to the supported ranges.
  always_comb begin
    if (vol_width_q == '0) w_eff = DW'(1);
    else if (DW'(vol_width_q) > DW'(MAX_WIDTH)) w_eff = DW'(MAX_WIDTH);
    else w_eff = DW'(vol_width_q);
    if (vol_height_q == '0) h_eff = DW'(1);
    else if (DW'(vol_height_q) > DW'(MAX_HEIGHT)) h_eff = DW'(MAX_HEIGHT);
    else h_eff = DW'(vol_height_q);
    if (vol_depth_q == '0) d_eff = DW'(1);
    else if (vol_depth_q > DW'(vdf_pkg::DEPTH_LIMIT)) d_eff = DW'(vdf_pkg::DEPTH_LIMIT);
    else d_eff = vol_depth_q;
    nc_eff = (n_comp_q == 2'd0) ? 2'd1 : n_comp_q;
  end

  // Edge detection on both positions.
  assign accept    = in_valid_i && in_ready_i;
  assign in_x_end  = (DW'(in_x_q) + DW'(1)) == w_eff;
  assign in_y_end  = (DW'(in_y_q) + DW'(1)) == h_eff;
  assign in_z_end  = (DW'(in_z_q) + DW'(1)) == d_eff;
  assign in_last   = in_x_end && in_y_end && in_z_end;
  assign out_x_end = (DW'(out_x_q) + DW'(1)) >= w_eff;
  assign out_y_end = (DW'(out_y_q) + DW'(1)) >= h_eff;
  assign out_z_end = (DW'(out_z_q) + DW'(1)) >= d_eff;
  assign out_last  = out_x_end && out_y_end && out_z_end;

  // Transaction decode: store a voxel, emit one result, both, or neither.
  always_comb begin
    write_o = accept && (action_i == vdf_pkg::ACT_VOXEL) && !done_q;
    emit_o  = accept && (((action_i == vdf_pkg::ACT_FLUSH) && done_q) ||
                         ((action_i == vdf_pkg::ACT_VOXEL) && !done_q && (in_z_q != '0)));
  end

  // Neighbour addresses; a missing neighbour reads the centre entry.
  always_comb begin
    xm = (out_x_q != '0) ? out_x_q - XB'(1) : out_x_q;
    xp = out_x_end ? out_x_q : out_x_q + XB'(1);
    ym = (out_y_q != '0) ? out_y_q - YB'(1) : out_y_q;
    yp = out_y_end ? out_y_q : out_y_q + YB'(1);
    waddr_o  = {in_z_q[0], in_y_q, in_x_q};
    ctr_o    = {out_z_q[0], out_y_q, out_x_q};
    x_prev_o = {out_z_q[0], out_y_q, xm};
    x_next_o = {out_z_q[0], out_y_q, xp};
    y_prev_o = {out_z_q[0], ym, out_x_q};
    y_next_o = {out_z_q[0], yp, out_x_q};
    z_prev_o = {(out_z_q != '0) ? ~out_z_q[0] : out_z_q[0], out_y_q, out_x_q};
    info_o.last   = out_last;
    info_o.use_y  = nc_eff >= 2'd2;
    info_o.use_z  = nc_eff == 2'd3;
    info_o.nz_sel = (action_i == vdf_pkg::ACT_VOXEL) && !out_z_end;
    info_o.nz     = comp_z_i;
  end

  assign scale_o = scale_q;
  assign cfg_hit = cfg_valid_i && (cfg_index_i <= vdf_pkg::REG_SCALE_Z);

  // Next state of registers and positions.
  always_comb begin
    vol_width_d  = vol_width_q;
    vol_height_d = vol_height_q;
    vol_depth_d  = vol_depth_q;
    n_comp_d     = n_comp_q;
    scale_d      = scale_q;
    in_x_d  = in_x_q;  in_y_d  = in_y_q;  in_z_d  = in_z_q;
    out_x_d = out_x_q; out_y_d = out_y_q; out_z_d = out_z_q;
    done_d  = done_q;
    if (cfg_hit) begin
      case (cfg_index_i)
        vdf_pkg::REG_VOL_WIDTH:  vol_width_d  = cfg_data_i[8:0];
        vdf_pkg::REG_VOL_HEIGHT: vol_height_d = cfg_data_i[8:0];
        vdf_pkg::REG_VOL_DEPTH:  vol_depth_d  = cfg_data_i[12:0];
        vdf_pkg::REG_N_COMP:     n_comp_d     = cfg_data_i[1:0];
        vdf_pkg::REG_SCALE_X:    scale_d.sx   = cfg_data_i;
        vdf_pkg::REG_SCALE_Y:    scale_d.sy   = cfg_data_i;
        vdf_pkg::REG_SCALE_Z:    scale_d.sz   = cfg_data_i;
        default:                 scale_d      = scale_q;
      endcase
      in_x_d = '0; in_y_d = '0; in_z_d = '0;
      out_x_d = '0; out_y_d = '0; out_z_d = '0;
      done_d = 1'b0;
    end else begin
      if (emit_o) begin
        if (!out_x_end) begin
          out_x_d = out_x_q + XB'(1);
        end else begin
          out_x_d = '0;
          if (!out_y_end) begin
            out_y_d = out_y_q + YB'(1);
          end else begin
            out_y_d = '0;
            out_z_d = out_z_q + ZW'(1);
          end
        end
        if (done_q && out_last) begin
          out_x_d = '0; out_y_d = '0; out_z_d = '0;
          done_d = 1'b0;
        end
      end
      if (write_o) begin
        if (in_last) begin
          in_x_d = '0; in_y_d = '0; in_z_d = '0;
          done_d = 1'b1;
        end else if (!in_x_end) begin
          in_x_d = in_x_q + XB'(1);
        end else begin
          in_x_d = '0;
          if (!in_y_end) begin
            in_y_d = in_y_q + YB'(1);
          end else begin
            in_y_d = '0;
            in_z_d = in_z_q + ZW'(1);
          end
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_width_q  <= 9'd256;
      vol_height_q <= 9'd256;
      vol_depth_q  <= 13'd1;
      n_comp_q     <= 2'd3;
      scale_q      <= '{sx: 18'd2048, sy: 18'd2048, sz: 18'd2048};
      in_x_q  <= '0; in_y_q  <= '0; in_z_q  <= '0;
      out_x_q <= '0; out_y_q <= '0; out_z_q <= '0;
      done_q  <= 1'b0;
    end else begin
      vol_width_q  <= vol_width_d;
      vol_height_q <= vol_height_d;
      vol_depth_q  <= vol_depth_d;
      n_comp_q     <= n_comp_d;
      scale_q      <= scale_d;
      in_x_q  <= in_x_d;  in_y_q  <= in_y_d;  in_z_q  <= in_z_d;
      out_x_q <= out_x_d; out_y_q <= out_y_d; out_z_q <= out_z_d;
      done_q  <= done_d;
    end
  end

  // While draining, the input position rests at the volume origin.
  a_done_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (in_x_q == '0 && in_y_q == '0 && in_z_q == '0))
    else $error("input position moved while draining");

  // A register write aborts the volume in progress.
  a_cfg_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (!done_q && out_x_q == '0 && out_y_q == '0 && out_z_q == '0))
    else $error("register write did not restart the volume");

  // Storing the final voxel of the volume starts the drain.
  a_last_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (write_o && in_last && !cfg_hit) |=> done_q)
    else $error("final voxel did not start draining");

endmodule

// ===== src/vdf_arith.sv =====
// Datapath of the divergence filter: differences, scaling, truncation and
// saturation, with the output register. Depends on vdf_pkg.
module vdf_arith (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   emit_i,
  input  vdf_pkg::emit_t                         info_i,
  input  vdf_pkg::scale_t                        scale_i,
  input  logic signed [vdf_pkg::SAMPLE_BITS-1:0] x_prev_i,
  input  logic signed [vdf_pkg::SAMPLE_BITS-1:0] x_next_i,
  input  logic signed [vdf_pkg::SAMPLE_BITS-1:0] y_prev_i,
  input  logic signed [vdf_pkg::SAMPLE_BITS-1:0] y_next_i,
  input  logic signed [vdf_pkg::SAMPLE_BITS-1:0] z_prev_i,
  input  logic signed [vdf_pkg::SAMPLE_BITS-1:0] z_ctr_i,
  output logic                                   ready_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [vdf_pkg::SAMPLE_BITS-1:0]        divergence_o,
  output logic                                   clipped_o,
  output logic                                   last_o
);

  localparam int SB = vdf_pkg::SAMPLE_BITS;
  localparam int PW = vdf_pkg::PROD_W;
  localparam int SW = vdf_pkg::SUM_W;

  logic                 v1_q, v2_q, v3_q;
  vdf_pkg::emit_t       info1_q;
  logic                 last2_q;
  logic signed [PW-1:0] px_q, py_q, pz_q;
  logic signed [SB-1:0] div_q;
  logic                 clip_q, last3_q;
  logic                 en2, en3;

  logic signed [SB:0]   dx, dy, dz;
  logic signed [SB-1:0] z_next;
  logic signed [SW-1:0] sum, sum_adj, q;
  logic signed [SB-1:0] div_d;
  logic                 clip_d;

  // Each stage moves when the one after it is empty or moving.
  assign en3     = !v3_q || out_ready_i;
  assign en2     = !v2_q || en3;
  assign ready_o = !v1_q || en2;

  // Differences of next and previous neighbours.
  always_comb begin
    z_next = info1_q.nz_sel ? info1_q.nz : z_ctr_i;
    dx = (SB+1)'(x_next_i) - (SB+1)'(x_prev_i);
    dy = (SB+1)'(y_next_i) - (SB+1)'(y_prev_i);
    dz = (SB+1)'(z_next)   - (SB+1)'(z_prev_i);
  end

  // Sum, truncation toward zero and saturation.
  always_comb begin
    sum     = SW'(px_q) + SW'(py_q) + SW'(pz_q);
    sum_adj = sum + ((sum < 0) ? SW'((1 << vdf_pkg::FRAC_BITS) - 1) : SW'(0));
    q       = sum_adj >>> vdf_pkg::FRAC_BITS;
    clip_d  = 1'b1;
    if (q > SW'((1 << (SB-1)) - 1)) begin
      div_d = {1'b0, {(SB-1){1'b1}}};
    end else if (q < -SW'(1 << (SB-1))) begin
      div_d = {1'b1, {(SB-1){1'b0}}};
    end else begin
      div_d  = q[SB-1:0];
      clip_d = 1'b0;
    end
  end

  // Pipeline valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready_o) v1_q <= emit_i;
      if (en2)     v2_q <= v1_q;
      if (en3)     v3_q <= v2_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      info1_q <= info_i;
    end
    if (en2) begin
      last2_q <= info1_q.last;
      px_q    <= PW'(dx * $signed({1'b0, scale_i.sx}));
      py_q    <= info1_q.use_y ? PW'(dy * $signed({1'b0, scale_i.sy})) : '0;
      pz_q    <= info1_q.use_z ? PW'(dz * $signed({1'b0, scale_i.sz})) : '0;
    end
    if (en3) begin
      div_q   <= div_d;
      clip_q  <= clip_d;
      last3_q <= last2_q;
    end
  end

  assign out_valid_o  = v3_q;
  assign divergence_o = div_q;
  assign clipped_o    = clip_q;
  assign last_o       = last3_q;

  // Input is held off only when the first stage holds a result.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> v1_q)
    else $error("input stalled with an empty pipeline");

  // A saturated result sits at one of the two limits.
  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && clip_q) |-> (div_q == {1'b0, {(SB-1){1'b1}}} || div_q == {1'b1, {(SB-1){1'b0}}}))
    else $error("clipped result not at a limit");

  // A result in stage one moves on when stage two is free.
  a_stage_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && en2) |=> v2_q)
    else $error("result lost between stages");

endmodule

// ===== src/volume_divergence_filter.sv =====
// Top level of the volume divergence filter: configuration, plane store
// banks and datapath. Depends on vdf_pkg, vdf_ctrl, vdf_bank and vdf_arith.
//
// Voxels arrive on the slave stream in raster order (x fastest), tuser = 0,
// tdata = {comp_z, comp_y, comp_x}. From the second plane on, each voxel
// transaction releases the divergence of the voxel one plane behind on the
// master stream; voxels of the first plane only fill the store. Once the
// whole volume is in, each transaction with tuser = 1 (flush) releases one
// result of the last plane; tlast marks the final voxel of the volume.
// A released result passes the plane store read, the product registers and the
// output register in that order before m_axis_tvalid rises.
// One transaction is taken per cycle while s_axis_tready is high: the plane
// store has one bank per component, each with one write and two read ports, so
// every neighbour is read in the cycle of acceptance. When the receiver stalls
// the results wait in a three-stage pipeline and the input is held off only
// once it is full. Reset clears positions and restores the register defaults;
// the store is not cleared. A register write restarts the volume; the user is
// to make it only while the block is idle, which the block does not enforce.
module volume_divergence_filter #(
  parameter int MAX_WIDTH  = vdf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = vdf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vdf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vdf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // comp_x, comp_y, comp_z
  input  logic                           s_axis_tuser,  // action
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // divergence
  output logic                           m_axis_tuser,  // clipped
  output logic                           m_axis_tlast   // last_voxel
);

  localparam int SB = vdf_pkg::SAMPLE_BITS;
  localparam int XB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = 1 + XB + YB;

  logic                 write, emit, ready;
  logic [AW-1:0]        waddr, x_prev_a, x_next_a, y_prev_a, y_next_a, z_prev_a, ctr_a;
  vdf_pkg::emit_t       info;
  vdf_pkg::scale_t      scale;
  logic signed [SB-1:0] x_prev, x_next, y_prev, y_next, z_prev, z_ctr;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ready;

  // Positions, registers and addresses.
  vdf_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .XB        (XB),
    .YB        (YB),
    .AW        (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_i (ready),
    .action_i   (s_axis_tuser),
    .comp_z_i   (s_axis_tdata[47:32]),
    .write_o    (write),
    .waddr_o    (waddr),
    .x_prev_o   (x_prev_a),
    .x_next_o   (x_next_a),
    .y_prev_o   (y_prev_a),
    .y_next_o   (y_next_a),
    .z_prev_o   (z_prev_a),
    .ctr_o      (ctr_a),
    .emit_o     (emit),
    .info_o     (info),
    .scale_o    (scale)
  );

  // Plane store, one bank per component.
  vdf_bank #(.AW(AW), .DW(SB)) u_bank_x (
    .clk_i    (clk_i),
    .we_i     (write),
    .waddr_i  (waddr),
    .wdata_i  (s_axis_tdata[15:0]),
    .re_i     (ready),
    .raddr_a_i(x_prev_a),
    .raddr_b_i(x_next_a),
    .rdata_a_o(x_prev),
    .rdata_b_o(x_next)
  );

  vdf_bank #(.AW(AW), .DW(SB)) u_bank_y (
    .clk_i    (clk_i),
    .we_i     (write),
    .waddr_i  (waddr),
    .wdata_i  (s_axis_tdata[31:16]),
    .re_i     (ready),
    .raddr_a_i(y_prev_a),
    .raddr_b_i(y_next_a),
    .rdata_a_o(y_prev),
    .rdata_b_o(y_next)
  );

  vdf_bank #(.AW(AW), .DW(SB)) u_bank_z (
    .clk_i    (clk_i),
    .we_i     (write),
    .waddr_i  (waddr),
    .wdata_i  (s_axis_tdata[47:32]),
    .re_i     (ready),
    .raddr_a_i(z_prev_a),
    .raddr_b_i(ctr_a),
    .rdata_a_o(z_prev),
    .rdata_b_o(z_ctr)
  );

  // Arithmetic and output register.
  vdf_arith u_arith (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .info_i      (info),
    .scale_i     (scale),
    .x_prev_i    (x_prev),
    .x_next_i    (x_next),
    .y_prev_i    (y_prev),
    .y_next_i    (y_next),
    .z_prev_i    (z_prev),
    .z_ctr_i     (z_ctr),
    .ready_o     (ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .divergence_o(m_axis_tdata),
    .clipped_o   (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

endmodule

// ===== dv/vdf_checker.sv =====
// Checker for the volume divergence filter: watches the configuration, input and
// output channels, predicts each divergence result and compares it field by field.
// Depends on vdf_pkg.
module vdf_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [vdf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vdf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // comp_x, comp_y, comp_z
  input  logic                           s_axis_tuser,  // action
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [15:0]                    m_axis_tdata,  // divergence
  input  logic                           m_axis_tuser,  // clipped
  input  logic                           m_axis_tlast,  // last_voxel
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);

  localparam int unsigned PLANE_SLOTS = vdf_pkg::DEF_MAX_WIDTH * vdf_pkg::DEF_MAX_HEIGHT;

  typedef struct {
    logic [15:0] divergence;
    logic        clipped;
    logic        last_voxel;
  } div_result_t;

  // Register copy, predicted positions and the two-plane voxel store.
  logic [8:0]                  width_q, height_q;
  logic [12:0]                 depth_q;
  logic [1:0]                  ncomp_q;
  logic [vdf_pkg::SCALE_W-1:0] scale_q [3];
  int unsigned                 in_pos, out_pos;
  bit                          draining;
  logic signed [15:0]          vox_store [0:2*PLANE_SLOTS-1][0:2];
  div_result_t                 expected_q [$];

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned slot(int unsigned x, int unsigned y, int unsigned z);
    return (z & 1) * PLANE_SLOTS + y * vdf_pkg::DEF_MAX_WIDTH + x;
  endfunction

  // Central difference per active axis; edges fall back to the centre voxel.
  function automatic div_result_t divergence_at(int unsigned o, bit has_nz,
                                                logic signed [15:0] nz_val);
    int unsigned w, h, d, nc, pl, x, y, z, ctr;
    int unsigned prev_i [3];
    int unsigned next_i [3];
    longint acc, q, nv;
    div_result_t r;
    w = clamp_dim(width_q, vdf_pkg::DEF_MAX_WIDTH);
    h = clamp_dim(height_q, vdf_pkg::DEF_MAX_HEIGHT);
    d = clamp_dim(depth_q, vdf_pkg::DEPTH_LIMIT);
    nc = clamp_dim(ncomp_q, 3);
    pl = w * h;
    x = o % w;
    y = (o / w) % h;
    z = o / pl;
    ctr = slot(x, y, z);
    prev_i[0] = x > 0 ? slot(x - 1, y, z) : ctr;
    next_i[0] = x + 1 < w ? slot(x + 1, y, z) : ctr;
    prev_i[1] = y > 0 ? slot(x, y - 1, z) : ctr;
    next_i[1] = y + 1 < h ? slot(x, y + 1, z) : ctr;
    prev_i[2] = z > 0 ? slot(x, y, z - 1) : ctr;
    next_i[2] = ctr;
    acc = 0;
    for (int c = 0; c < nc; c++) begin
      if (c == 2 && has_nz && z + 1 < d) nv = longint'(nz_val);
      else nv = longint'(vox_store[next_i[c]][c]);
      acc += (nv - longint'(vox_store[prev_i[c]][c])) * longint'(scale_q[c]);
    end
    q = acc / (longint'(1) << vdf_pkg::FRAC_BITS);
    r.clipped = 1'b0;
    if (q > 32767) begin
      q = 32767;
      r.clipped = 1'b1;
    end
    if (q < -32768) begin
      q = -32768;
      r.clipped = 1'b1;
    end
    r.divergence = q[15:0];
    r.last_voxel = (o + 1 == pl * d);
    return r;
  endfunction

  // Track every transaction on the three channels.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned w, h, d, pl, total, z;
    logic signed [15:0] v [3];
    div_result_t exp_r;
    if (!rst_ni) begin
      width_q <= 9'd256;
      height_q <= 9'd256;
      depth_q <= 13'd1;
      ncomp_q <= 2'd3;
      for (int i = 0; i < 3; i++) scale_q[i] <= 18'd2048;
      in_pos = 0;
      out_pos = 0;
      draining = 0;
      fail_count_o <= 0;
      checked_o <= 0;
    end else begin
      // Output side is compared against the oldest expectation.
      if (m_axis_tvalid && m_axis_tready) begin
        checked_o <= checked_o + 1;
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("ERROR: unexpected result div=%0d clip=%0b last=%0b",
                     $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (m_axis_tdata !== exp_r.divergence || m_axis_tuser !== exp_r.clipped ||
              m_axis_tlast !== exp_r.last_voxel) begin
            if (fail_count_o < 10)
              $display("ERROR: exp div=%0d clip=%0b last=%0b, got div=%0d clip=%0b last=%0b",
                       $signed(exp_r.divergence), exp_r.clipped, exp_r.last_voxel,
                       $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // A register write restarts the volume.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          vdf_pkg::REG_VOL_WIDTH:  width_q <= cfg_data_i[8:0];
          vdf_pkg::REG_VOL_HEIGHT: height_q <= cfg_data_i[8:0];
          vdf_pkg::REG_VOL_DEPTH:  depth_q <= cfg_data_i[12:0];
          vdf_pkg::REG_N_COMP:     ncomp_q <= cfg_data_i[1:0];
          vdf_pkg::REG_SCALE_X:    scale_q[0] <= cfg_data_i;
          vdf_pkg::REG_SCALE_Y:    scale_q[1] <= cfg_data_i;
          vdf_pkg::REG_SCALE_Z:    scale_q[2] <= cfg_data_i;
          default: ;
        endcase
        if (cfg_index_i <= vdf_pkg::REG_SCALE_Z) begin
          in_pos = 0;
          out_pos = 0;
          draining = 0;
        end
      end
      // Input side: voxels fill the store, flushes drain the last plane.
      if (s_axis_tvalid && s_axis_tready) begin
        w = clamp_dim(width_q, vdf_pkg::DEF_MAX_WIDTH);
        h = clamp_dim(height_q, vdf_pkg::DEF_MAX_HEIGHT);
        d = clamp_dim(depth_q, vdf_pkg::DEPTH_LIMIT);
        pl = w * h;
        total = pl * d;
        if (vdf_pkg::action_e'(s_axis_tuser) == vdf_pkg::ACT_FLUSH) begin
          if (draining) begin
            expected_q.push_back(divergence_at(out_pos, 1'b0, 16'sd0));
            if (out_pos + 1 >= total) begin
              out_pos = 0;
              in_pos = 0;
              draining = 0;
            end else begin
              out_pos++;
            end
          end
        end else if (!draining) begin
          v[0] = s_axis_tdata[15:0];
          v[1] = s_axis_tdata[31:16];
          v[2] = s_axis_tdata[47:32];
          z = in_pos / pl;
          if (z >= 1) begin
            expected_q.push_back(divergence_at(out_pos, 1'b1, v[2]));
            out_pos++;
          end
          for (int c = 0; c < 3; c++) vox_store[slot(in_pos % w, (in_pos / w) % h, z)][c] = v[c];
          if (in_pos + 1 >= total) begin
            in_pos = 0;
            draining = 1;
          end else begin
            in_pos++;
          end
        end
      end
    end
  end

  assign pending_o = expected_q.size();

endmodule

// ===== dv/tb.sv =====
// Testbench top for the volume divergence filter: clock, reset, stimulus on the
// configuration and input channels, receiver stalls, watchdog and verdict.
// Depends on vdf_pkg, volume_divergence_filter and vdf_checker.
module tb;

  localparam int IDLE_LIMIT = 4000;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [vdf_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [vdf_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [47:0]                    s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [15:0]                    m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;
  int                             fail_count, pending, checked;
  int                             idle_cycles = 0;
  int                             cycle_cnt = 0;
  int                             burst_left = 0;
  int                             item_cnt = 0;
  int                             volume_cnt = 0;

  always #1 clk_i = ~clk_i;

  volume_divergence_filter u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  vdf_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // Receiver stalls: free running, random, then a periodic long stall.
  always @(negedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    case ((cycle_cnt / 700) % 3)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ((cycle_cnt % 16) < 5);
    endcase
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding.", pending);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(vdf_pkg::cfg_idx_t idx, int unsigned value);
    cfg_index_i <= idx;
    cfg_data_i <= value[vdf_pkg::CFG_DATA_W-1:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One input transaction; the sender pauses between bursts of random length.
  task automatic send_item(vdf_pkg::action_e act, logic [15:0] cx, logic [15:0] cy,
                           logic [15:0] cz);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tdata <= {cz, cy, cx};
    s_axis_tuser <= act;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (burst_left == 0) s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_scale();
    case ($urandom_range(0, 4))
      0:       return 2048;
      1:       return 262143;
      2:       return $urandom_range(0, 8192);
      default: return $urandom_range(0, 262143);
    endcase
  endfunction

  // Waits until every expected result has come and the pipeline has emptied.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Programs a volume, streams it (with noise when noisy is set), and drains it unless cut short.
  task automatic run_volume(int unsigned w, int unsigned h, int unsigned d, int unsigned nc,
                            int unsigned sx, int unsigned sy, int unsigned sz,
                            bit cut_short, bit noisy);
    int unsigned ew, eh, ed, pl, total, n_sent;
    settle();
    write_reg(vdf_pkg::REG_VOL_WIDTH, w);
    write_reg(vdf_pkg::REG_VOL_HEIGHT, h);
    write_reg(vdf_pkg::REG_VOL_DEPTH, d);
    write_reg(vdf_pkg::REG_N_COMP, nc);
    write_reg(vdf_pkg::REG_SCALE_X, sx);
    write_reg(vdf_pkg::REG_SCALE_Y, sy);
    write_reg(vdf_pkg::REG_SCALE_Z, sz);
    ew = (w == 0) ? 1 : (w > 256 ? 256 : w);
    eh = (h == 0) ? 1 : (h > 256 ? 256 : h);
    ed = (d == 0) ? 1 : (d > 4096 ? 4096 : d);
    pl = ew * eh;
    total = pl * ed;
    n_sent = cut_short ? $urandom_range(1, total) : total;
    volume_cnt++;
    for (int unsigned i = 0; i < n_sent; i++) begin
      // A flush before the volume is complete is ignored.
      if (noisy && $urandom_range(0, 15) == 0)
        send_item(vdf_pkg::ACT_FLUSH, pick_comp(), 16'd0, 16'd0);
      send_item(vdf_pkg::ACT_VOXEL, pick_comp(), pick_comp(), pick_comp());
      item_cnt++;
    end
    if (!cut_short) begin
      for (int unsigned i = 0; i < pl; i++) begin
        // A voxel while draining is ignored.
        if (noisy && $urandom_range(0, 15) == 0)
          send_item(vdf_pkg::ACT_VOXEL, pick_comp(), pick_comp(), pick_comp());
        send_item(vdf_pkg::ACT_FLUSH, pick_comp(), pick_comp(), pick_comp());
        item_cnt++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: all-zero registers, saturating scales, each component count.
    run_volume(0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
    run_volume(3, 2, 2, 3, 262143, 262143, 262143, 1'b0, 1'b1);
    run_volume(2, 2, 2, 2, 2048, 4096, 1, 1'b0, 1'b0);

    // Extreme sizes, including clamped register values.
    run_volume(511, 1, 2, 1, pick_scale(), pick_scale(), pick_scale(), 1'b0, 1'b1);
    run_volume(1, 511, 1, 2, pick_scale(), pick_scale(), pick_scale(), 1'b0, 1'b1);

    // Random small volumes, some aborted partway by the next register write.
    while (item_cnt < 1700) begin
      run_volume($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(1, 4),
                 $urandom_range(0, 3), pick_scale(), pick_scale(), pick_scale(),
                 $urandom_range(0, 5) == 0, 1'b1);
    end

    settle();
    $display("Ran %0d volumes with %0d voxel and flush transactions; %0d results checked.",
             volume_cnt, item_cnt, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/vdf_pkg.sv
src/vdf_bank.sv
src/vdf_ctrl.sv
src/vdf_arith.sv
src/volume_divergence_filter.sv
dv/vdf_checker.sv
dv/tb.sv
